// ===== sv/swsc_pkg.sv =====
package swsc_pkg;

  // Event codes on the input channel.
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    K_SEND   = 2'd0,
    K_DONE   = 2'd1,
    K_GIVEUP = 2'd2,
    K_NOACT  = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_WINDOW_SIZE  = 3'd0,
    CFG_PACKET_COUNT = 3'd1,
    CFG_FINAL_LENGTH = 3'd2,
    CFG_MAX_TRIES    = 3'd3,
    CFG_CLOSE_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEND,
    ST_CLOSE
  } state_e;

  localparam int unsigned SEQ_W    = 10;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned OFS_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 11;

  localparam logic [3:0]       WINDOW_SIZE_RST  = 4'd4;
  localparam logic [SEQ_W-1:0] PACKET_COUNT_RST = 10'd10;
  localparam logic [LEN_W-1:0] FINAL_LENGTH_RST = 11'd8;
  localparam logic [2:0]       MAX_TRIES_RST    = 3'd5;
  localparam logic [3:0]       CLOSE_LIMIT_RST  = 4'd10;

  localparam logic [SEQ_W-1:0] SEQ_MAX = '1;
  localparam logic [3:0]       FSEND_MAX = 4'd15;

endpackage

// ===== sv/sliding_window_sender_control_top.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | operation_i, ack_number_i
// out     | output    | out_valid_o/out_ready_i | kind_o, seq_number_o, payload_length_o,
//         |           |                         | final_flag_o, byte_offset_o, last_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An event is accepted in ST_IDLE and decided in ST_DECIDE; ST_SEND then issues one
// result per cycle while the output is free, set by the single sequence incrementer
// and range compares. A give-up after a burst is issued from ST_CLOSE, as is the
// status result of a window with no packet in range. Reset is asynchronous: it clears
// base, next, retry and final-send counts and the finished flag and loads the register
// reset values. A stalled output holds the sequencer; no new event is taken until the
// current one has issued its last result into the output register.
module sliding_window_sender_control_top
  import swsc_pkg::*;
#(
  parameter int unsigned CHUNK_BYTES = 8,
  parameter int unsigned MAX_WINDOW  = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [SEQ_W-1:0]     ack_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [SEQ_W-1:0]     seq_number_o,
  output logic [LEN_W-1:0]     payload_length_o,
  output logic                 final_flag_o,
  output logic [OFS_W-1:0]     byte_offset_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam logic [5:0] MaxWin = 6'(MAX_WINDOW);

  // Configuration registers.
  logic [3:0]       window_size_q;
  logic [SEQ_W-1:0] packet_count_q;
  logic [LEN_W-1:0] final_length_q;
  logic [2:0]       max_tries_q;
  logic [3:0]       close_limit_q;

  state_e           state_q, state_d;
  logic [SEQ_W-1:0] base_q, base_d;
  logic [SEQ_W-1:0] next_q, next_d;
  logic [2:0]       retry_q, retry_d;
  logic [3:0]       fsends_q, fsends_d;
  logic             fin_q, fin_d;
  op_e              op_q, op_d;
  logic [SEQ_W-1:0] ack_q, ack_d;
  logic [SEQ_W:0]   s_q, s_d;
  logic [SEQ_W:0]   upto_q, upto_d;
  logic             upd_q, upd_d;

  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             ffl_q, ffl_d;
  logic [OFS_W-1:0] ofs_q, ofs_d;
  logic             last_q, last_d;

  logic             slot_free;
  logic [5:0]       win;
  logic [SEQ_W:0]   s_nxt;
  logic [SEQ_W:0]   pc_ext;
  logic             s_in_range, nxt_in_range;
  logic             s_is_final;
  logic [3:0]       fs_after;
  logic             emit;
  kind_e            e_kind;
  logic [SEQ_W-1:0] e_seq;
  logic             e_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign slot_free   = !out_valid_q || out_ready_i;

  // Effective window: zero counts as one, clipped at the configured maximum.
  always_comb begin
    win = {2'b00, window_size_q};
    if (window_size_q == 4'd0) begin
      win = 6'd1;
    end
    if (win > MaxWin) begin
      win = MaxWin;
    end
  end

  // Shared step unit: one incrementer and the range compares on it.
  assign pc_ext       = {1'b0, packet_count_q};
  assign s_nxt        = s_q + 1'b1;
  assign s_in_range   = (s_q <= upto_q) && (s_q <= pc_ext);
  assign nxt_in_range = (s_nxt <= upto_q) && (s_nxt <= pc_ext);
  assign s_is_final   = (s_q == pc_ext);
  assign fs_after     = (s_is_final && fsends_q != FSEND_MAX) ? fsends_q + 4'd1 : fsends_q;

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    next_d  = next_q;
    retry_d = retry_q;
    fsends_d = fsends_q;
    fin_d   = fin_q;
    op_d    = op_q;
    ack_d   = ack_q;
    s_d     = s_q;
    upto_d  = upto_q;
    upd_d   = upd_q;
    emit    = 1'b0;
    e_kind  = K_NOACT;
    e_seq   = '0;
    e_last  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(operation_i);
          ack_d   = ack_number_i;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
          if (fin_q || op_q == OP_NONE) begin
            emit = 1'b1;
          end else if (op_q == OP_START || op_q == OP_TIMEOUT) begin
            if (op_q == OP_TIMEOUT && retry_q >= max_tries_q) begin
              emit   = 1'b1;
              e_kind = K_GIVEUP;
              fin_d  = 1'b1;
            end else begin
              if (op_q == OP_TIMEOUT) begin
                retry_d = retry_q + 3'd1;
              end
              s_d     = {1'b0, base_q};
              upto_d  = {1'b0, base_q} + {5'd0, win} - 1'b1;
              upd_d   = 1'b1;
              state_d = ST_SEND;
            end
          end else if (ack_q == packet_count_q) begin
            emit   = 1'b1;
            e_kind = K_DONE;
            fin_d  = 1'b1;
          end else if (ack_q < packet_count_q && ack_q == base_q) begin
            // Duplicate ack: resend the named packet without moving next_seq.
            s_d     = {1'b0, ack_q};
            upto_d  = {1'b0, ack_q};
            upd_d   = 1'b0;
            state_d = ST_SEND;
          end else if (ack_q < packet_count_q && ack_q > base_q) begin
            base_d  = ack_q;
            s_d     = (next_q > ack_q) ? {1'b0, next_q} : {1'b0, ack_q};
            upto_d  = {1'b0, ack_q} + {5'd0, win} - 1'b1;
            upd_d   = 1'b1;
            state_d = ST_SEND;
          end else begin
            emit = 1'b1;
          end
        end
      end
      ST_SEND: begin
        if (!s_in_range) begin
          state_d = ST_CLOSE;
        end else if (slot_free) begin
          emit     = 1'b1;
          e_kind   = K_SEND;
          e_seq    = s_q[SEQ_W-1:0];
          e_last   = !nxt_in_range && (fs_after < close_limit_q);
          fsends_d = fs_after;
          if (upd_q) begin
            next_d = (s_q[SEQ_W-1:0] == SEQ_MAX) ? SEQ_MAX : s_nxt[SEQ_W-1:0];
          end
          s_d = s_nxt;
          if (e_last) begin
            state_d = ST_IDLE;
          end else if (!nxt_in_range) begin
            state_d = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        // Reached either with nothing sent or with the close limit hit.
        if (slot_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (fsends_q >= close_limit_q) begin
            e_kind = K_GIVEUP;
            fin_d  = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register fields.
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d = kind_q;
    seq_d  = seq_q;
    len_d  = len_q;
    ffl_d  = ffl_q;
    ofs_d  = ofs_q;
    last_d = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      kind_d = e_kind;
      last_d = e_last;
      if (e_kind == K_SEND) begin
        seq_d = e_seq;
        ffl_d = (e_seq == packet_count_q);
        len_d = (e_seq == packet_count_q) ? final_length_q : LEN_W'(CHUNK_BYTES);
        ofs_d = {{(OFS_W-SEQ_W){1'b0}}, e_seq} * OFS_W'(CHUNK_BYTES);
      end else begin
        seq_d = '0;
        ffl_d = 1'b0;
        len_d = '0;
        ofs_d = '0;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      retry_q     <= '0;
      fsends_q    <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      window_size_q  <= WINDOW_SIZE_RST;
      packet_count_q <= PACKET_COUNT_RST;
      final_length_q <= FINAL_LENGTH_RST;
      max_tries_q    <= MAX_TRIES_RST;
      close_limit_q  <= CLOSE_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      retry_q     <= retry_d;
      fsends_q    <= fsends_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WINDOW_SIZE:  window_size_q  <= cfg_data_i[3:0];
          CFG_PACKET_COUNT: packet_count_q <= cfg_data_i[SEQ_W-1:0];
          CFG_FINAL_LENGTH: final_length_q <= cfg_data_i;
          CFG_MAX_TRIES:    max_tries_q    <= cfg_data_i[2:0];
          CFG_CLOSE_LIMIT:  close_limit_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ack_q  <= ack_d;
    s_q    <= s_d;
    upto_q <= upto_d;
    upd_q  <= upd_d;
    kind_q <= kind_d;
    seq_q  <= seq_d;
    len_q  <= len_d;
    ffl_q  <= ffl_d;
    ofs_q  <= ofs_d;
    last_q <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign seq_number_o     = seq_q;
  assign payload_length_o = len_q;
  assign final_flag_o     = ffl_q;
  assign byte_offset_o    = ofs_q;
  assign last_o           = last_q;

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("finished flag cleared without reset");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != K_SEND |-> last_q)
    else $error("status result not marked last");

  a_final_is_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ffl_q |-> kind_q == K_SEND)
    else $error("final flag on a non-send result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("event accepted without leaving idle");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import swsc_pkg::*;

  localparam int unsigned CHUNK_BYTES    = 8;
  localparam int unsigned MAX_WINDOW     = 15;
  localparam int unsigned RANDOM_EVENTS  = 364;
  localparam int unsigned RANDOM_PHASES  = 4;
  // Window advances stop this far below the final packet, so the random part never closes.
  localparam int unsigned FINAL_MARGIN   = 60;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned END_SPIN_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [SEQ_W-1:0]     TOP_BASE       = 10'd1020;

  typedef struct packed {
    kind_e             kind;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic              fin;
    logic [OFS_W-1:0]  ofs;
    logic              last;
  } send_cmd_t;

  typedef enum int {
    END_COMPLETE,
    END_RETRIES,
    END_CLOSE
  } ending_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           operation_i;
  logic [SEQ_W-1:0]     ack_number_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [1:0]           kind_o;
  logic [SEQ_W-1:0]     seq_number_o;
  logic [LEN_W-1:0]     payload_length_o;
  logic                 final_flag_o;
  logic [OFS_W-1:0]     byte_offset_o;
  logic                 last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  sliding_window_sender_control_top #(
    .CHUNK_BYTES(CHUNK_BYTES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .ack_number_i    (ack_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .seq_number_o    (seq_number_o),
    .payload_length_o(payload_length_o),
    .final_flag_o    (final_flag_o),
    .byte_offset_o   (byte_offset_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Register mirror and window state of the sender.
  logic [3:0]       cfg_window;
  logic [SEQ_W-1:0] cfg_pkt_count;
  logic [LEN_W-1:0] cfg_final_len;
  logic [2:0]       cfg_max_tries;
  logic [3:0]       cfg_close_limit;
  int unsigned      wnd_base;
  int unsigned      wnd_next;
  int unsigned      retries;
  int unsigned      final_sends;
  bit               xfer_over;

  send_cmd_t   event_cmds[$];
  send_cmd_t   expected_cmds[$];
  send_cmd_t   head_cmd;
  int unsigned error_count;
  int unsigned events_sent;
  int unsigned cmds_checked;
  int unsigned cfg_writes;
  bit          no_stall;
  ending_e     end_mode;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned draw_gap();
    if (no_stall) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic void reset_model();
    cfg_window      = WINDOW_SIZE_RST;
    cfg_pkt_count   = PACKET_COUNT_RST;
    cfg_final_len   = FINAL_LENGTH_RST;
    cfg_max_tries   = MAX_TRIES_RST;
    cfg_close_limit = CLOSE_LIMIT_RST;
    wnd_base        = 0;
    wnd_next        = 0;
    retries         = 0;
    final_sends     = 0;
    xfer_over       = 1'b0;
  endfunction

  function automatic int unsigned eff_window();
    if (cfg_window == 0) return 1;
    if (cfg_window > MAX_WINDOW) return MAX_WINDOW;
    return cfg_window;
  endfunction

  function automatic void add_cmd(input kind_e k, input int unsigned seq);
    send_cmd_t c;
    logic      is_final;
    is_final = (k == K_SEND) && (seq == cfg_pkt_count);
    c = '0;
    c.kind = k;
    if (k == K_SEND) begin
      c.seq = seq[SEQ_W-1:0];
      c.len = is_final ? cfg_final_len : LEN_W'(CHUNK_BYTES);
      c.ofs = OFS_W'(seq * CHUNK_BYTES);
    end
    c.fin = is_final;
    if (is_final && final_sends < FSEND_MAX) final_sends++;
    event_cmds.push_back(c);
  endfunction

  function automatic void send_window(input int unsigned first, input int unsigned upto);
    int unsigned s;
    bit          any;
    s = first;
    any = 1'b0;
    while (s <= upto && s <= cfg_pkt_count && s <= SEQ_MAX) begin
      add_cmd(K_SEND, s);
      s++;
      any = 1'b1;
    end
    if (any) wnd_next = (s > SEQ_MAX) ? SEQ_MAX : s;
  endfunction

  function automatic void check_close();
    if (final_sends >= cfg_close_limit) begin
      add_cmd(K_GIVEUP, 0);
      xfer_over = 1'b1;
    end
  endfunction

  // Works out the results of one accepted event and queues them in order.
  function automatic void predict_event(input op_e op, input logic [SEQ_W-1:0] ack);
    int unsigned w;
    int unsigned a;
    int unsigned first;
    send_cmd_t   tail;
    w = eff_window();
    a = ack;
    event_cmds.delete();
    if (!xfer_over) begin
      if (op == OP_START || op == OP_TIMEOUT) begin
        if (op == OP_TIMEOUT && retries >= cfg_max_tries) begin
          add_cmd(K_GIVEUP, 0);
          xfer_over = 1'b1;
        end else begin
          if (op == OP_TIMEOUT) retries++;
          send_window(wnd_base, wnd_base + w - 1);
          check_close();
        end
      end else if (op == OP_ACK) begin
        if (a == cfg_pkt_count) begin
          add_cmd(K_DONE, 0);
          xfer_over = 1'b1;
        end else if (a < cfg_pkt_count && a == wnd_base) begin
          add_cmd(K_SEND, a);
          check_close();
        end else if (a < cfg_pkt_count && a > wnd_base) begin
          first = (wnd_next > a) ? wnd_next : a;
          wnd_base = a;
          send_window(first, a + w - 1);
          check_close();
        end
      end
    end
    if (event_cmds.size() == 0) add_cmd(K_NOACT, 0);
    tail = event_cmds.pop_back();
    tail.last = 1'b1;
    event_cmds.push_back(tail);
    foreach (event_cmds[i]) expected_cmds.push_back(event_cmds[i]);
  endfunction

  task automatic send_event(input op_e op, input logic [SEQ_W-1:0] ack);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    ack_number_i <= ack;
    do @(posedge clk_i); while (!in_ready_o);
    predict_event(op, ack);
    events_sent++;
  endtask

  // Every event yields at least one result, so an empty queue means the block is idle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_WINDOW_SIZE:  cfg_window      = data[3:0];
      CFG_PACKET_COUNT: cfg_pkt_count   = data[SEQ_W-1:0];
      CFG_FINAL_LENGTH: cfg_final_len   = data[LEN_W-1:0];
      CFG_MAX_TRIES:    cfg_max_tries   = data[2:0];
      CFG_CLOSE_LIMIT:  cfg_close_limit = data[3:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0d expected %0d (seq %0d)", name, got, want, head_cmd.seq));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (expected_cmds.size() == 0) begin
        report_error($sformatf("unexpected result kind %0d seq %0d", kind_o, seq_number_o));
      end else begin
        head_cmd = expected_cmds.pop_front();
        cmds_checked++;
        check_field("kind", kind_o, head_cmd.kind);
        check_field("seq_number", seq_number_o, head_cmd.seq);
        check_field("payload_length", payload_length_o, head_cmd.len);
        check_field("final_flag", final_flag_o, head_cmd.fin);
        check_field("byte_offset", byte_offset_o, head_cmd.ofs);
        check_field("last", last_o, head_cmd.last);
      end
    end
  end

  // Result side: a fresh stall is drawn for every transaction.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Reset values, every event kind, duplicate, stale and out-of-range acks, final packet.
  task automatic test_reset_values();
    send_event(OP_START, '0);
    send_event(OP_NONE, SEQ_MAX);
    send_event(OP_ACK, 10'd0);
    send_event(OP_ACK, 10'd2);
    send_event(OP_ACK, 10'd1);
    send_event(OP_ACK, 10'd11);
    send_event(OP_TIMEOUT, '0);
    send_event(OP_ACK, 10'd8);
  endtask

  // Window of zero, a final packet moved below the window, and a write to no register.
  task automatic test_config_corners();
    wait_idle();
    write_reg(CFG_WINDOW_SIZE, '0);
    send_event(OP_START, '0);
    wait_idle();
    write_reg(CFG_PACKET_COUNT, 11'd1);
    write_reg(CFG_UNUSED_IDX, '1);
    send_event(OP_START, '0);
    send_event(OP_ACK, 10'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned      phase_events;
    int unsigned      phase;
    int unsigned      w;
    int unsigned      roll;
    int unsigned      pick;
    logic [SEQ_W-1:0] ack;
    op_e              op;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(CFG_WINDOW_SIZE, 11'd1);
          write_reg(CFG_PACKET_COUNT, 11'd999);
          write_reg(CFG_FINAL_LENGTH, 11'd1024);
        end
        1: begin
          write_reg(CFG_WINDOW_SIZE, 11'd15);
          write_reg(CFG_PACKET_COUNT, CFG_DAT_W'($urandom_range(960, 999)));
          write_reg(CFG_FINAL_LENGTH, '0);
        end
        2: begin
          write_reg(CFG_WINDOW_SIZE, CFG_DAT_W'($urandom_range(1, 15)));
          write_reg(CFG_PACKET_COUNT, 11'd999);
          write_reg(CFG_FINAL_LENGTH, '1);
        end
        default: begin
          write_reg(CFG_WINDOW_SIZE, CFG_DAT_W'($urandom_range(2, 14)));
          write_reg(CFG_FINAL_LENGTH, CFG_DAT_W'($urandom_range(0, 2047)));
        end
      endcase
      write_reg(CFG_MAX_TRIES, 11'd7);
      write_reg(CFG_CLOSE_LIMIT, CFG_DAT_W'($urandom_range(12, 15)));
      no_stall = (phase == 2);
      phase_events = 0;
      while (phase_events < RANDOM_EVENTS / RANDOM_PHASES) begin
        w = eff_window();
        roll = $urandom_range(0, 99);
        ack = SEQ_W'($urandom);
        if (roll < 12) begin
          op = OP_START;
        end else if (roll < 20) begin
          op = (retries < cfg_max_tries) ? OP_TIMEOUT : OP_START;
        end else if (roll < 35) begin
          op = OP_ACK;
          ack = SEQ_W'(wnd_base);
        end else if (roll < 85) begin
          op = OP_ACK;
          if (wnd_base + FINAL_MARGIN < cfg_pkt_count) begin
            ack = SEQ_W'(wnd_base + $urandom_range(1, w + 3));
          end else begin
            ack = SEQ_W'(wnd_base);
          end
        end else begin
          pick = $urandom_range(0, 2);
          if (pick == 0 && wnd_base > 0) begin
            op = OP_ACK;
            ack = SEQ_W'($urandom_range(0, wnd_base - 1));
          end else if (pick == 1) begin
            op = OP_ACK;
            ack = SEQ_W'($urandom_range(cfg_pkt_count + 1, SEQ_MAX));
          end else begin
            op = OP_NONE;
          end
        end
        send_event(op, ack);
        phase_events++;
      end
    end
    no_stall = 1'b0;
  endtask

  // The final packet at the top of the sequence space; next_seq has to saturate.
  task automatic test_sequence_top();
    wait_idle();
    write_reg(CFG_CLOSE_LIMIT, 11'd15);
    write_reg(CFG_WINDOW_SIZE, 11'd15);
    write_reg(CFG_PACKET_COUNT, CFG_DAT_W'(SEQ_MAX));
    write_reg(CFG_FINAL_LENGTH, '1);
    send_event(OP_ACK, TOP_BASE);
    send_event(OP_START, '0);
    send_event(OP_ACK, TOP_BASE + 10'd1);
  endtask

  // Only one transfer ending fits in a run, so the seed picks which one is exercised.
  task automatic test_termination();
    end_mode = ending_e'($urandom_range(0, 2));
    case (end_mode)
      END_COMPLETE: begin
        send_event(OP_ACK, SEQ_MAX);
      end
      END_RETRIES: begin
        wait_idle();
        write_reg(CFG_MAX_TRIES, '0);
        send_event(OP_TIMEOUT, '0);
      end
      default: begin
        wait_idle();
        write_reg(CFG_CLOSE_LIMIT, 11'd1);
        send_event(OP_ACK, SEQ_W'(wnd_base));
      end
    endcase
    // Once the transfer has ended nothing but no-action results may come back.
    send_event(OP_START, '0);
    send_event(OP_ACK, SEQ_W'(wnd_base));
    send_event(OP_TIMEOUT, '0);
    send_event(OP_NONE, '0);
  endtask

  initial begin
    int unsigned spins;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OP_START;
    ack_number_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    error_count  = 0;
    events_sent  = 0;
    cmds_checked = 0;
    cfg_writes   = 0;
    no_stall     = 1'b0;
    end_mode     = END_COMPLETE;
    reset_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_config_corners();
    test_random_traffic();
    test_sequence_top();
    test_termination();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    spins = 0;
    while (expected_cmds.size() != 0 && spins < END_SPIN_LIMIT) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_cmds.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_cmds.size()));
    end
    $display("Run covered %0d events, %0d checked results and %0d register writes.",
             events_sent, cmds_checked, cfg_writes);
    $display("The transfer was ended by %s.", end_mode.name());
    if (error_count == 0) begin
      $display("sliding_window_sender_control_top regression: pass");
    end else begin
      $display("sliding_window_sender_control_top regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Watchdog expired with %0d results outstanding.", expected_cmds.size());
    $display("sliding_window_sender_control_top regression: fail");
    $finish;
  end

endmodule
